// ===== rtl/stra_pkg.sv =====
package stra_pkg;

   localparam int CFG_W = 11;
   localparam int VAL_W = 32;
   localparam int OP_W  = 2;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B_L0,
      ST_B_LVL,
      ST_B_RA,
      ST_B_RB,
      ST_B_VA,
      ST_B_VB,
      ST_B_WR,
      ST_Q_SCAN,
      ST_Q_TAB,
      ST_Q_VAL
   } state_type;

   typedef struct packed {
      logic ld_wr;
      logic q_start;
      logic q_shift;
      logic q_tab_rd;
      logic q_val_rd;
      logic q_update;
      logic rsp_load;
      logic b_start;
      logic b_l0_wr;
      logic b_lvl_init;
      logic b_next_lvl;
      logic b_next_sel;
      logic b_rd_a;
      logic b_rd_b;
      logic b_rd_va;
      logic b_rd_vb;
      logic b_wr;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic q_bit;
      logic n_zero;
      logic pos_eq_n;
      logic lvl_ok;
      logic pos_eq_last;
      logic sel;
      logic rsp_free;
   } status_type;

endpackage

// ===== rtl/stra_ram.sv =====
module stra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/stra_ctrl.sv =====
module stra_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [stra_pkg::OP_W-1:0]   req_op,
   output logic                        req_ready,
   input  stra_pkg::status_type        status,
   output stra_pkg::cmd_type           cmd
);
   import stra_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_BUILD: state_in = ST_B_L0;
                  OP_QUERY: state_in = ST_Q_SCAN;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_B_L0: begin
            if (status.n_zero) begin
               state_in = ST_IDLE;
            end else if (status.pos_eq_n) begin
               state_in = ST_B_LVL;
            end
         end
         ST_B_LVL: begin
            if (status.lvl_ok) begin
               state_in = ST_B_RA;
            end else if (!status.sel) begin
               state_in = ST_B_L0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_B_RA: state_in = ST_B_RB;
         ST_B_RB: state_in = ST_B_VA;
         ST_B_VA: state_in = ST_B_VB;
         ST_B_VB: state_in = ST_B_WR;
         ST_B_WR: state_in = status.pos_eq_last ? ST_B_LVL : ST_B_RA;
         ST_Q_SCAN: begin
            if (status.len_zero) begin
               if (status.rsp_free) begin
                  state_in = ST_IDLE;
               end
            end else if (status.q_bit) begin
               state_in = ST_Q_TAB;
            end
         end
         ST_Q_TAB: state_in = ST_Q_VAL;
         ST_Q_VAL: state_in = ST_Q_SCAN;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_LOAD:  cmd.ld_wr   = 1'b1;
                  OP_BUILD: cmd.b_start = 1'b1;
                  OP_QUERY: cmd.q_start = 1'b1;
                  default:  cmd = '0;
               endcase
            end
         end
         ST_B_L0: begin
            if (!status.n_zero) begin
               cmd.b_l0_wr    = 1'b1;
               cmd.b_lvl_init = status.pos_eq_n;
            end
         end
         ST_B_LVL: begin
            cmd.b_next_sel = !status.lvl_ok && !status.sel;
         end
         ST_B_RA: cmd.b_rd_a  = 1'b1;
         ST_B_RB: cmd.b_rd_b  = 1'b1;
         ST_B_VA: cmd.b_rd_va = 1'b1;
         ST_B_VB: cmd.b_rd_vb = 1'b1;
         ST_B_WR: begin
            cmd.b_wr       = 1'b1;
            cmd.b_next_lvl = status.pos_eq_last;
         end
         ST_Q_SCAN: begin
            if (status.len_zero) begin
               cmd.rsp_load = status.rsp_free;
            end else if (status.q_bit) begin
               cmd.q_tab_rd = 1'b1;
            end else begin
               cmd.q_shift = 1'b1;
            end
         end
         ST_Q_TAB: cmd.q_val_rd = 1'b1;
         ST_Q_VAL: cmd.q_update = 1'b1;
         default:  cmd = '0;
      endcase
   end

endmodule

// ===== rtl/stra_dp.sv =====
module stra_dp #(
   parameter int DEPTH  = 1024,
   parameter int LEVELS = 11,
   parameter int IW     = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_array_sel,
   input  logic [IW-1:0]                 req_index,
   input  logic [stra_pkg::VAL_W-1:0]    req_value,
   input  logic [IW-1:0]                 req_left,
   input  logic [IW-1:0]                 req_right,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [IW-1:0]                 rsp_max_index,
   output logic [stra_pkg::VAL_W-1:0]    rsp_max_value,
   input  logic                          csr_we,
   input  logic [stra_pkg::CFG_W-1:0]    csr_wdata,
   input  stra_pkg::cmd_type             cmd,
   output stra_pkg::status_type          status
);
   import stra_pkg::*;

   localparam int SW    = IW + 1;
   localparam int MAXL  = (LEVELS > IW) ? LEVELS : IW;
   localparam int LCW   = $clog2(MAXL + 1);
   localparam int RW    = $clog2(2 * LEVELS);
   localparam int VAW   = $clog2(2 * DEPTH);
   localparam int TAW   = $clog2(2 * LEVELS * DEPTH);

   logic [CFG_W-1:0] alen_ff, alen_in;
   logic             sel_ff, sel_in;
   logic [IW-1:0]    pos_ff, pos_in;
   logic [LCW-1:0]   lvl_ff, lvl_in;
   logic [IW-1:0]    len_ff, len_in;
   logic [IW-1:0]    a_ff, a_in;
   logic [IW-1:0]    b_ff, b_in;
   logic [VAL_W-1:0] va_ff, va_in;
   logic [IW-1:0]    best_ff, best_in;
   logic [VAL_W-1:0] bestv_ff, bestv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [VAL_W-1:0] rsp_val_ff, rsp_val_in;

   logic [IW-1:0]    n;
   logic [SW-1:0]    span, last, half;
   logic             q_ok, ld_ok;

   logic             tab_re, tab_we;
   logic [LCW-1:0]   rd_lvl, wr_lvl;
   logic [IW-1:0]    rd_pos;
   logic [RW-1:0]    rd_row, wr_row;
   logic [TAW-1:0]   tab_raddr, tab_waddr;
   logic [IW-1:0]    tab_wdata, tab_q;

   logic             val_re;
   logic [IW-1:0]    val_src;
   logic [VAW-1:0]   val_raddr, val_waddr;
   logic [VAL_W-1:0] val_q;

   assign n    = (int'(alen_ff) > DEPTH) ? IW'(DEPTH) : IW'(alen_ff);
   assign span = SW'(1) << lvl_ff;
   assign half = span >> 1;
   assign last = SW'(n) - span + SW'(1);

   assign q_ok  = (req_left != '0) && (req_right >= req_left) && (int'(req_right) <= DEPTH);
   assign ld_ok = (req_index != '0) && (int'(req_index) <= DEPTH);

   assign status.len_zero    = (len_ff == '0);
   assign status.q_bit       = len_ff[0] && (int'(lvl_ff) < LEVELS);
   assign status.n_zero      = (n == '0);
   assign status.pos_eq_n    = (pos_ff == n);
   assign status.lvl_ok      = (int'(lvl_ff) < LEVELS) && (int'(lvl_ff) <= IW) &&
                               (span <= SW'(n));
   assign status.pos_eq_last = (SW'(pos_ff) == last);
   assign status.sel         = sel_ff;
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   // table address: (sel * LEVELS + level) * DEPTH + pos - 1
   assign tab_re    = cmd.q_tab_rd || cmd.b_rd_a || cmd.b_rd_b;
   assign rd_lvl    = cmd.q_tab_rd ? lvl_ff : lvl_ff - LCW'(1);
   assign rd_pos    = cmd.b_rd_b ? pos_ff + IW'(half) : pos_ff;
   assign rd_row    = RW'(sel_ff ? LEVELS : 0) + RW'(rd_lvl);
   assign tab_raddr = TAW'(rd_row) * TAW'(DEPTH) + TAW'(rd_pos - IW'(1));

   assign tab_we    = cmd.b_l0_wr || cmd.b_wr;
   assign wr_lvl    = cmd.b_l0_wr ? '0 : lvl_ff;
   assign wr_row    = RW'(sel_ff ? LEVELS : 0) + RW'(wr_lvl);
   assign tab_waddr = TAW'(wr_row) * TAW'(DEPTH) + TAW'(pos_ff - IW'(1));
   // ties go to the right half
   assign tab_wdata = cmd.b_l0_wr ? pos_ff : ((va_ff > val_q) ? a_ff : b_ff);

   assign val_re    = cmd.q_val_rd || cmd.b_rd_va || cmd.b_rd_vb;
   assign val_src   = cmd.q_val_rd ? tab_q : (cmd.b_rd_va ? a_ff : b_ff);
   assign val_raddr = VAW'(sel_ff ? DEPTH : 0) + VAW'(val_src - IW'(1));
   assign val_waddr = VAW'(req_array_sel ? DEPTH : 0) + VAW'(req_index - IW'(1));

   stra_ram #(.WIDTH(IW), .DEPTH(2 * LEVELS * DEPTH)) u_tab (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_en   (tab_re),
      .rd_addr (tab_raddr),
      .rd_data (tab_q)
   );

   stra_ram #(.WIDTH(VAL_W), .DEPTH(2 * DEPTH)) u_val (
      .clock   (clock),
      .wr_en   (cmd.ld_wr && ld_ok),
      .wr_addr (val_waddr),
      .wr_data (req_value),
      .rd_en   (val_re),
      .rd_addr (val_raddr),
      .rd_data (val_q)
   );

   always_comb begin
      alen_in      = csr_we ? csr_wdata : alen_ff;
      sel_in       = sel_ff;
      pos_in       = pos_ff;
      lvl_in       = lvl_ff;
      len_in       = len_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      va_in        = va_ff;
      best_in      = best_ff;
      bestv_in     = bestv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;

      if (cmd.q_start) begin
         sel_in   = req_array_sel;
         pos_in   = req_left;
         lvl_in   = '0;
         len_in   = q_ok ? (req_right - req_left + IW'(1)) : '0;
         best_in  = '0;
         bestv_in = '0;
      end
      if (cmd.q_shift) begin
         len_in = len_ff >> 1;
         lvl_in = lvl_ff + LCW'(1);
      end
      if (cmd.q_val_rd) begin
         a_in = tab_q;
      end
      if (cmd.q_update) begin
         if (val_q > bestv_ff) begin
            best_in  = a_ff;
            bestv_in = val_q;
         end
         pos_in = pos_ff + IW'(span);
         len_in = len_ff >> 1;
         lvl_in = lvl_ff + LCW'(1);
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = best_ff;
         rsp_val_in   = bestv_ff;
      end

      if (cmd.b_start) begin
         sel_in = 1'b0;
         pos_in = IW'(1);
         lvl_in = '0;
      end
      if (cmd.b_l0_wr) begin
         pos_in = pos_ff + IW'(1);
      end
      if (cmd.b_lvl_init) begin
         pos_in = IW'(1);
         lvl_in = LCW'(1);
      end
      if (cmd.b_next_sel) begin
         sel_in = 1'b1;
         pos_in = IW'(1);
         lvl_in = '0;
      end
      if (cmd.b_rd_b) begin
         a_in = tab_q;
      end
      if (cmd.b_rd_va) begin
         b_in = tab_q;
      end
      if (cmd.b_rd_vb) begin
         va_in = val_q;
      end
      if (cmd.b_wr) begin
         pos_in = pos_ff + IW'(1);
      end
      if (cmd.b_next_lvl) begin
         pos_in = IW'(1);
         lvl_in = lvl_ff + LCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alen_ff      <= alen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff     <= sel_in;
      pos_ff     <= pos_in;
      lvl_ff     <= lvl_in;
      len_ff     <= len_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      va_ff      <= va_in;
      best_ff    <= best_in;
      bestv_ff   <= bestv_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_index = rsp_idx_ff;
   assign rsp_max_value = rsp_val_ff;

endmodule

// ===== rtl/sparse_table_range_argmax.sv =====
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    op, array_sel, index, value, left, right
// rsp       out        rsp_valid / rsp_ready    max_index, max_value
// csr       in         csr_we (no wait)         array_length
//
// Load: written at acceptance, no busy state. Query: a start step, then per length
// bit a shift if clear, or a table read, then a value read and an update if set.
// Build: per array a level-0 write per entry, then per entry of each higher level
// the steps read, read, value, value, write, and a level check per level.
// Reset clears the controller, array_length and the response valid only.
// A held response stalls the next query at its last step; loads and builds pass.
module sparse_table_range_argmax #(
   parameter  int DEPTH  = 1024,
   parameter  int LEVELS = 11,
   localparam int IW     = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [stra_pkg::OP_W-1:0]     req_op,
   input  logic                          req_array_sel,
   input  logic [IW-1:0]                 req_index,
   input  logic [stra_pkg::VAL_W-1:0]    req_value,
   input  logic [IW-1:0]                 req_left,
   input  logic [IW-1:0]                 req_right,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [IW-1:0]                 rsp_max_index,
   output logic [stra_pkg::VAL_W-1:0]    rsp_max_value,
   input  logic                          csr_we,
   input  logic [stra_pkg::CFG_W-1:0]    csr_wdata
);
   import stra_pkg::*;

   cmd_type    cmd;
   status_type status;

   stra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   stra_dp #(.DEPTH(DEPTH), .LEVELS(LEVELS), .IW(IW)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_array_sel (req_array_sel),
      .req_index     (req_index),
      .req_value     (req_value),
      .req_left      (req_left),
      .req_right     (req_right),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_max_index (rsp_max_index),
      .rsp_max_value (rsp_max_value),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .status        (status)
   );

`ifndef SYNTHESIS
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("not idle after reset");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_QUERY) |=> !req_ready)
      else $error("query transfer did not start the scan");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op != OP_QUERY) |=> !$rose(rsp_valid))
      else $error("response raised by a non-query transfer");
`endif

endmodule
